@@ design/adsr_pkg.sv @@
// Shared types, codes and helpers for the ADSR envelope generator.
`default_nettype none

package adsr_pkg;

  localparam int unsigned STEP_W    = 22;
  localparam int unsigned SUSTAIN_W = 10;
  localparam int unsigned LEVEL_W   = 10;
  localparam int unsigned PHASE_W   = 3;
  localparam int unsigned INDEX_W   = 2;

  // Configuration register indexes.
  localparam logic [INDEX_W-1:0] REG_ATTACK_STEP   = 2'd0;
  localparam logic [INDEX_W-1:0] REG_DECAY_STEP    = 2'd1;
  localparam logic [INDEX_W-1:0] REG_SUSTAIN_LEVEL = 2'd2;
  localparam logic [INDEX_W-1:0] REG_RELEASE_STEP  = 2'd3;

  localparam logic [STEP_W-1:0]    ATTACK_STEP_RST   = 22'd2235;
  localparam logic [STEP_W-1:0]    DECAY_STEP_RST    = 22'd2235;
  localparam logic [SUSTAIN_W-1:0] SUSTAIN_LEVEL_RST = 10'd0;
  localparam logic [STEP_W-1:0]    RELEASE_STEP_RST  = 22'd2235;

  // Phase codes as they appear on the result stream.
  localparam logic [PHASE_W-1:0] PHASE_CODE_IDLE    = 3'd0;
  localparam logic [PHASE_W-1:0] PHASE_CODE_ATTACK  = 3'd1;
  localparam logic [PHASE_W-1:0] PHASE_CODE_DECAY   = 3'd2;
  localparam logic [PHASE_W-1:0] PHASE_CODE_SUSTAIN = 3'd3;
  localparam logic [PHASE_W-1:0] PHASE_CODE_RELEASE = 3'd4;

  typedef enum logic [4:0] {
    PH_IDLE    = 5'b00001,
    PH_ATTACK  = 5'b00010,
    PH_DECAY   = 5'b00100,
    PH_SUSTAIN = 5'b01000,
    PH_RELEASE = 5'b10000
  } phase_e;

  typedef struct packed {
    phase_e phase;
    logic   oneshot;
    logic   gate_seen;
  } ctrl_t;

  typedef struct packed {
    logic [STEP_W-1:0]    attack_step;
    logic [STEP_W-1:0]    decay_step;
    logic [SUSTAIN_W-1:0] sustain_level;
    logic [STEP_W-1:0]    release_step;
  } cfg_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [LEVEL_W-1:0] level;
  } result_t;

  function automatic logic [PHASE_W-1:0] phase_code(phase_e ph);
    logic [PHASE_W-1:0] code;
    unique case (ph)
      PH_ATTACK:  code = PHASE_CODE_ATTACK;
      PH_DECAY:   code = PHASE_CODE_DECAY;
      PH_SUSTAIN: code = PHASE_CODE_SUSTAIN;
      PH_RELEASE: code = PHASE_CODE_RELEASE;
      default:    code = PHASE_CODE_IDLE;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

@@ design/adsr_step.sv @@
// Next-state logic for one sample tick: control rules, one phase step and clamping.
`default_nettype none

module adsr_step import adsr_pkg::*; #(
  parameter int unsigned LEVEL_BITS    = 10,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  wire logic                                  gate_i,
  input  wire logic                                  trigger_i,
  input  wire ctrl_t                                 ctrl_i,
  input  wire logic [LEVEL_BITS+FRACTION_BITS-1:0]   acc_i,
  input  wire cfg_t                                  cfg_i,
  output ctrl_t                                      ctrl_o,
  output logic [LEVEL_BITS+FRACTION_BITS-1:0]        acc_o,
  output logic                                       emit_o,
  output result_t                                    result_o
);

  localparam int unsigned ACC_W = LEVEL_BITS + FRACTION_BITS;
  localparam int unsigned SUM_W = ((ACC_W > STEP_W) ? ACC_W : STEP_W) + 2;
  localparam int unsigned LVX_W = (LEVEL_BITS > LEVEL_W) ? LEVEL_BITS : LEVEL_W;

  localparam logic [ACC_W-1:0] FULL_ACC = {{LEVEL_BITS{1'b1}}, {FRACTION_BITS{1'b0}}};

  logic [LVX_W-1:0]        sus_ext;
  logic [LVX_W-1:0]        full_lvl;
  logic [LVX_W-1:0]        sus_lim;
  logic [ACC_W-1:0]        sus_acc;
  logic signed [SUM_W-1:0] sus_s;
  logic signed [SUM_W-1:0] full_s;
  logic signed [SUM_W-1:0] acc_s;
  logic [LVX_W-1:0]        level_ext;

  // Sustain is limited to full scale when the level field is narrower than the register.
  assign sus_ext  = LVX_W'(cfg_i.sustain_level);
  assign full_lvl = LVX_W'({LEVEL_BITS{1'b1}});
  assign sus_lim  = (sus_ext > full_lvl) ? full_lvl : sus_ext;
  assign sus_acc  = {sus_lim[LEVEL_BITS-1:0], {FRACTION_BITS{1'b0}}};
  assign sus_s    = signed'(SUM_W'(sus_acc));
  assign full_s   = signed'(SUM_W'(FULL_ACC));
  assign acc_s    = signed'(SUM_W'(acc_i));

  always_comb begin
    ctrl_t                   c;
    logic signed [SUM_W-1:0] sum;
    c   = ctrl_i;
    sum = acc_s;

    if (trigger_i && !c.oneshot) begin
      c.oneshot = 1'b1;
      c.phase   = PH_ATTACK;
    end
    if (gate_i && !c.gate_seen) begin
      c.phase     = PH_ATTACK;
      c.gate_seen = 1'b1;
    end else if (!gate_i && !c.oneshot) begin
      c.phase     = PH_RELEASE;
      c.gate_seen = 1'b0;
    end

    emit_o = (c.phase != PH_IDLE);

    unique case (c.phase)
      PH_ATTACK: begin
        sum = acc_s + signed'(SUM_W'(cfg_i.attack_step));
        if (sum >= full_s) begin
          c.oneshot = 1'b0;
          c.phase   = PH_DECAY;
        end
      end
      PH_DECAY: begin
        sum = acc_s - signed'(SUM_W'(cfg_i.decay_step));
        if (sum <= sus_s) begin
          c.phase = PH_SUSTAIN;
        end
      end
      PH_SUSTAIN: begin
        sum = sus_s;
      end
      PH_RELEASE: begin
        sum = acc_s - signed'(SUM_W'(cfg_i.release_step));
        // The sign bit marks an overshoot below zero.
        if (sum[SUM_W-1] || (sum == '0)) begin
          c.phase = PH_IDLE;
        end
      end
      default: begin
        c.phase = PH_IDLE;
      end
    endcase

    if (sum[SUM_W-1]) begin
      acc_o = '0;
    end else if (sum > full_s) begin
      acc_o = FULL_ACC;
    end else begin
      acc_o = sum[ACC_W-1:0];
    end

    ctrl_o = c;
  end

  // The emitted level is the integer part, kept to the width of the result field.
  assign level_ext = LVX_W'(acc_o[ACC_W-1:FRACTION_BITS]);
  assign result_o  = '{phase: phase_code(ctrl_o.phase), level: level_ext[LEVEL_W-1:0]};

endmodule

`default_nettype wire

@@ design/adsr_envelope_generator.sv @@
// Top level of the linear ADSR envelope generator with its stream ports and registers.
`default_nettype none

// Linear ADSR envelope generator. Each input request is one sample tick carrying the
// gate level (bit 0) and trigger level (bit 1). The block applies the gate and trigger
// rules, advances the envelope by one step, clamps it to 0..full scale and returns one
// result request (level and phase) for every tick that is not idle. One tick is taken
// every clock cycle while the spare output entry is empty; each result is registered
// in the output register or the spare entry. The accumulator update is one add,
// compare and clamp. A two-entry output buffer keeps the input ready registered: when
// the output stalls, one more result is held in the spare entry, and the input then
// stalls until the output drains. Steps are unsigned fixed-point values with
// FRACTION_BITS fraction bits. The user must write registers through the cfg port
// only while the block is idle; the block itself does not enforce this.
module adsr_envelope_generator import adsr_pkg::*; #(
  parameter int unsigned LEVEL_BITS    = 10,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [7:0]           s_axis_tdata,   // gate_level, trigger_level
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [15:0]               m_axis_tdata,   // level[9:0], phase[12:10]
  input  wire logic                 cfg_we_i,
  input  wire logic [INDEX_W-1:0]   cfg_index_i,
  input  wire logic [STEP_W-1:0]    cfg_wdata_i
);

  localparam int unsigned ACC_W = LEVEL_BITS + FRACTION_BITS;
  localparam logic [ACC_W-1:0] FULL_ACC = {{LEVEL_BITS{1'b1}}, {FRACTION_BITS{1'b0}}};

  cfg_t             cfg_q;
  ctrl_t            ctrl_q, ctrl_d;
  logic [ACC_W-1:0] acc_q, acc_d;
  logic             emit;
  result_t          result;

  logic             out_valid_q, out_valid_d;
  result_t          out_data_q, out_data_d;
  logic             skid_valid_q, skid_valid_d;
  result_t          skid_data_q, skid_data_d;
  logic             in_take;
  logic             out_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.attack_step   <= ATTACK_STEP_RST;
      cfg_q.decay_step    <= DECAY_STEP_RST;
      cfg_q.sustain_level <= SUSTAIN_LEVEL_RST;
      cfg_q.release_step  <= RELEASE_STEP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_ATTACK_STEP:   cfg_q.attack_step   <= cfg_wdata_i;
        REG_DECAY_STEP:    cfg_q.decay_step    <= cfg_wdata_i;
        REG_SUSTAIN_LEVEL: cfg_q.sustain_level <= cfg_wdata_i[SUSTAIN_W-1:0];
        REG_RELEASE_STEP:  cfg_q.release_step  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  adsr_step #(
    .LEVEL_BITS    (LEVEL_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_step (
    .gate_i    (s_axis_tdata[0]),
    .trigger_i (s_axis_tdata[1]),
    .ctrl_i    (ctrl_q),
    .acc_i     (acc_q),
    .cfg_i     (cfg_q),
    .ctrl_o    (ctrl_d),
    .acc_o     (acc_d),
    .emit_o    (emit),
    .result_o  (result)
  );

  assign s_axis_tready = !skid_valid_q;
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign out_pop       = out_valid_q && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '{phase: PH_IDLE, oneshot: 1'b0, gate_seen: 1'b0};
      acc_q  <= '0;
    end else if (in_take) begin
      ctrl_q <= ctrl_d;
      acc_q  <= acc_d;
    end
  end

  // Output register backed by one skid entry.
  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    if (!out_valid_q || out_pop) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = in_take && emit;
        out_data_d  = result;
      end
    end else if (in_take && emit) begin
      skid_valid_d = 1'b1;
      skid_data_d  = result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = 16'({out_data_q.phase, out_data_q.level});

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held while output register is empty");

  a_acc_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_q <= FULL_ACC)
    else $error("accumulator above full scale");

  a_idle_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_q.phase == PH_IDLE) |-> (acc_q == '0))
    else $error("idle phase with nonzero accumulator");

  a_oneshot_in_attack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_q.oneshot |-> (ctrl_q.phase == PH_ATTACK))
    else $error("one-shot pending outside attack");

  a_stall_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready && in_take && emit) |=> skid_valid_q)
    else $error("result lost while output stalled");

endmodule

`default_nettype wire
